// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge outside reset.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that prop never holds at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_ON(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)

`endif

`endif

// ===== design/fpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared codes, word layouts and scan token types of the partition allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpfa_pkg;

	localparam int OP_W   = 2;
	localparam int SLOT_W = 6;
	localparam int AMT_W  = 16;
	localparam int ST_W   = 2;
	localparam int MODE_W = 2;
	localparam int CNT_W  = 7;

	// Opcodes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	// Fit modes (the fourth code acts as first fit)
	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	// Result status
	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_FIT_MODE = 1'b0;
	localparam logic CFG_ENTRIES  = 1'b1;

	localparam logic [CNT_W-1:0] ENTRIES_RESET = 7'd64;

	localparam int IN_W      = 24;
	localparam int OUT_W     = 32;
	localparam int OUT_PAD_W = 7;

	typedef struct packed {
		logic [AMT_W-1:0]  amount;
		logic [SLOT_W-1:0] slot_index;
		logic [OP_W-1:0]   opcode;
	} in_word_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [AMT_W-1:0]  chosen_size;
		logic [SLOT_W-1:0] chosen_slot;
		logic              granted;
	} out_word_t;

	// Command broadcast to every cell while one item is in flight
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [MODE_W-1:0] mode;
	} scan_cmd_t;

	// Control part of the token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
	} scan_ctl_t;

endpackage

`default_nettype wire

// ===== design/fpfa_cell.sv =====
// ----------------------------------------------------------------------------
// fpfa_cell
// One partition: its size and allocated mark, plus one hop of the scan token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpfa_cell
	import fpfa_pkg::*;
#(
	parameter int ENTRIES    = 64,
	parameter int SIZE_WIDTH = 16,
	parameter int IDX        = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire scan_cmd_t                     cmd,
	input  wire logic [SLOT_W-1:0]             slot,
	input  wire logic [SIZE_WIDTH-1:0]         amount,
	input  wire logic [$clog2(ENTRIES+1)-1:0]  live_n,
	input  wire logic                          commit_valid,
	input  wire logic [$clog2(ENTRIES)-1:0]    commit_idx,
	input  wire scan_ctl_t                     prev_ctl,
	input  wire logic [$clog2(ENTRIES)-1:0]    prev_idx,
	input  wire logic [SIZE_WIDTH-1:0]         prev_size,
	output scan_ctl_t                          next_ctl,
	output logic [$clog2(ENTRIES)-1:0]         next_idx,
	output logic [SIZE_WIDTH-1:0]              next_size
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int LW = (CW > SLOT_W) ? CW : SLOT_W;

	logic [SIZE_WIDTH-1:0] size_q;
	logic                  mark_q;
	scan_ctl_t             ctl_q;
	logic [IW-1:0]         idx_q;
	logic [SIZE_WIDTH-1:0] bsize_q;

	logic is_live, slot_hit, fits, better, take, wr_slot;

	always_comb begin
		is_live  = CW'(IDX) < live_n;
		slot_hit = LW'(slot) == LW'(IDX);
		wr_slot  = prev_ctl.valid && slot_hit && is_live;
		fits     = prev_ctl.valid && (cmd.op == OP_ALLOC) && is_live && !mark_q &&
			(size_q >= amount);
		better   = ((cmd.mode == FIT_BEST) && (size_q < prev_size)) ||
			((cmd.mode == FIT_WORST) && (size_q > prev_size));
		take     = fits && (!prev_ctl.found || better);
	end

	// Mark: set by the grant commit, cleared by load or release of this slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			ctl_q.valid <= prev_ctl.valid;
			ctl_q.found <= prev_ctl.found | fits;
			if (commit_valid && (commit_idx == IW'(IDX))) begin
				mark_q <= 1'b1;
			end else if (wr_slot && ((cmd.op == OP_LOAD) || (cmd.op == OP_RELEASE))) begin
				mark_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_slot && (cmd.op == OP_LOAD)) begin
			size_q <= amount;
		end
		idx_q   <= take ? IW'(IDX) : prev_idx;
		bsize_q <= take ? size_q : prev_size;
	end

	assign next_ctl  = ctl_q;
	assign next_idx  = idx_q;
	assign next_size = bsize_q;

endmodule

`default_nettype wire

// ===== design/fixed_partition_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed-partition allocator with first, best and worst fit placement.
//
// The table lives in a row of ENTRIES cells, one partition per cell. Every
// word taken on the slave stream (load, allocate, release or unused opcode)
// launches a token that walks the row one cell per clock; a load or release
// lands in the addressed cell as the token passes, and an allocate collects
// the winning index and size on the way. When the token leaves the last
// cell the grant sets that partition's mark and one result word is formed.
// A word's path from acceptance to the output register runs through the start
// register, the cell row and the park register; tready rises again when the
// result moves from the park register into the output register, so the block
// takes no new word before then. A stalled master side holds tready low
// once a second result is parked behind the one on the output. One word is
// in flight at a time, and a new word is taken while the previous result
// still waits on the master side. Sizes of partitions never loaded are
// unknown, so load every partition in use before the first allocate. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fixed_partition_fit_allocator_core
	import fpfa_pkg::*;
#(
	parameter int ENTRIES    = 64,
	parameter int SIZE_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write port
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CNT_W-1:0] cfg_data,
	// slave stream
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // opcode[1:0], slot_index[7:2], amount[23:8]
	// master stream
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata   // granted[0], chosen_slot[6:1],
	                                             // chosen_size[22:7], status[24:23]
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int EW = (CW > CNT_W) ? CW : CNT_W;
	localparam int LW = (CW > SLOT_W) ? CW : SLOT_W;

	// configuration registers
	logic [MODE_W-1:0] fit_mode_q;
	logic [CNT_W-1:0]  entries_q;
	logic [CW-1:0]     live_n;

	// item held for the duration of the walk
	in_word_t              in_word;
	logic                  accept;
	logic                  busy_q;
	logic                  start_q;
	logic [OP_W-1:0]       op_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [SIZE_WIDTH-1:0] amt_q;
	logic                  range_err_q;
	scan_cmd_t             cmd;

	// cell row links
	scan_ctl_t             chain_ctl  [ENTRIES+1];
	logic [IW-1:0]         chain_idx  [ENTRIES+1];
	logic [SIZE_WIDTH-1:0] chain_size [ENTRIES+1];
	logic [ENTRIES:0]      chain_vld;

	// tail side
	scan_ctl_t             tail_ctl;
	logic                  commit_valid;
	out_word_t             res_d;
	out_word_t             pend_q;
	logic                  pend_valid_q;
	out_word_t             out_q;
	logic                  out_valid_q;
	logic                  move;

	// Config writes; the entry count saturates to the table size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
			entries_q  <= ENTRIES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIT_MODE: fit_mode_q <= cfg_data[MODE_W-1:0];
				CFG_ENTRIES:  entries_q  <= cfg_data;
				default:      entries_q  <= entries_q;
			endcase
		end
	end

	assign live_n = (EW'(entries_q) > EW'(ENTRIES)) ? CW'(ENTRIES) : CW'(entries_q);

	// Take a word only when no token is walking and no result is parked
	assign in_word       = in_word_t'(s_axis_tdata);
	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Hold the word's fields while its token walks the row
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= in_word.opcode;
			slot_q      <= in_word.slot_index;
			amt_q       <= SIZE_WIDTH'(in_word.amount);
			range_err_q <= !(LW'(in_word.slot_index) < LW'(live_n));
		end
	end

	assign cmd.op   = op_q;
	assign cmd.mode = fit_mode_q;

	// Launch the token at the head of the row
	assign chain_ctl[0].valid = start_q;
	assign chain_ctl[0].found = 1'b0;
	assign chain_idx[0]       = '0;
	assign chain_size[0]      = '0;

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			fpfa_cell #(
				.ENTRIES    (ENTRIES),
				.SIZE_WIDTH (SIZE_WIDTH),
				.IDX        (gi)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cmd          (cmd),
				.slot         (slot_q),
				.amount       (amt_q),
				.live_n       (live_n),
				.commit_valid (commit_valid),
				.commit_idx   (chain_idx[ENTRIES]),
				.prev_ctl     (chain_ctl[gi]),
				.prev_idx     (chain_idx[gi]),
				.prev_size    (chain_size[gi]),
				.next_ctl     (chain_ctl[gi+1]),
				.next_idx     (chain_idx[gi+1]),
				.next_size    (chain_size[gi+1])
			);
		end
		for (gi = 0; gi <= ENTRIES; gi++) begin : g_vld
			assign chain_vld[gi] = chain_ctl[gi].valid;
		end
	endgenerate

	// Token leaves the row: commit a grant and form the result word
	assign tail_ctl     = chain_ctl[ENTRIES];
	assign commit_valid = tail_ctl.valid && (op_q == OP_ALLOC) && tail_ctl.found;

	always_comb begin
		res_d = '0;
		case (op_q)
			OP_ALLOC: begin
				if (tail_ctl.found) begin
					res_d.granted     = 1'b1;
					res_d.chosen_slot = SLOT_W'(chain_idx[ENTRIES]);
					res_d.chosen_size = AMT_W'(chain_size[ENTRIES]);
					res_d.status      = ST_DONE;
				end else begin
					res_d.status = ST_NOFIT;
				end
			end
			OP_LOAD, OP_RELEASE: begin
				res_d.status = range_err_q ? ST_RANGE : ST_DONE;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Park the result, then advance it into the output register when free
	assign move = pend_valid_q && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (tail_ctl.valid) begin
				pend_valid_q <= 1'b1;
			end else if (move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_ctl.valid) begin
			pend_q <= res_d;
		end
		if (move) begin
			out_q <= pend_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q};

	// Only one token may walk the row at a time
	`ASSERT_ON(a_one_token, clk, arst_n, $onehot0(chain_vld))
	// A token only leaves the row for a word in flight with the park slot empty
	`ASSERT_ON(a_tail_busy, clk, arst_n, tail_ctl.valid |-> (busy_q && !pend_valid_q))
	// Grants only come from allocate words
	`ASSERT_NEVER(a_commit_op, clk, arst_n, commit_valid && (op_q != OP_ALLOC))
	// A word cannot be taken while its predecessor is still walking
	`ASSERT_ON(a_no_overlap, clk, arst_n, accept |=> !(s_axis_tvalid && s_axis_tready))

endmodule

`default_nettype wire
